[rtl/ctd_pkg.sv]
`default_nettype none

package ctd_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Image size after reset
  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 11'd8;

  // Sub-block geometry
  localparam int TEXELS = 16;

  // Alpha codes
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // One compressed sub-block
  typedef struct packed {
    logic [15:0] endpoint_first;
    logic [15:0] endpoint_second;
    logic [31:0] index_rows;
  } in_item_t;

  // One decoded texel
  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_texel;
  } out_item_t;

  // One palette entry
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

endpackage

`default_nettype wire

[rtl/cmpr_block_texel_decoder.sv]
`default_nettype none

// Decodes one 4x4 CMPR (BC1-style) sub-block per input item into RGBA8 texels
// with image coordinates, one texel per cycle on the output channel while the
// receiver does not stall it. The first stage expands the endpoints, builds the
// four-entry palette and marks which texels fall inside the image; the second
// stage walks the marked texels in row-major order into the output register. A
// sub-block emits only the texels that fall inside the image, and one entirely
// outside emits nothing; the single output register delivers one texel a cycle
// unless out_ready holds it. The next item is taken in the cycle its predecessor
// hands over its final texel, so a stream of full sub-blocks runs at one texel
// every cycle while out_ready stays high. An accepted item passes through the
// decoded sub-block register and then the output register. Writing either size
// register restarts the tile walk at the image origin.
module cmpr_block_texel_decoder #(
  parameter int MAX_DIM = 1024
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  ctd_pkg::in_item_t                    in_item,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output ctd_pkg::out_item_t                   out_item,
  input  wire                                  cfg_we,
  input  wire  [ctd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [ctd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  import ctd_pkg::*;

  // Position width: holds a tile base plus the tile size
  localparam int PW = $clog2(MAX_DIM) + 1;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // (5*near + 3*far) >> 3
  function automatic logic [7:0] blend58(input logic [7:0] near, input logic [7:0] far);
    logic [10:0] s;
    s = 11'(near) * 11'd5 + 11'(far) * 11'd3;
    return s[10:3];
  endfunction

  function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = 9'(a) + 9'(b);
    return s[8:1];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration and tile position
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] width_r, width_nxt;
  logic [CFG_DATA_W-1:0] height_r, height_nxt;
  logic [PW-1:0]         tile_x_r, tile_x_nxt;
  logic [PW-1:0]         tile_y_r, tile_y_nxt;
  logic [1:0]            sub_r, sub_nxt;

  logic [PW-1:0] w_eff, h_eff;
  logic [PW-1:0] tile_x_step, tile_y_step;
  logic          accept;

  assign accept = in_valid && in_ready;

  // Clamp to the largest supported dimension
  assign w_eff = (32'(width_r) > MAX_DIM) ? PW'(MAX_DIM) : PW'(width_r);
  assign h_eff = (32'(height_r) > MAX_DIM) ? PW'(MAX_DIM) : PW'(height_r);

  assign tile_x_step = tile_x_r + PW'(8);
  assign tile_y_step = tile_y_r + PW'(8);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    tile_x_nxt = tile_x_r;
    tile_y_nxt = tile_y_r;
    sub_nxt    = sub_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_nxt  = cfg_wdata;
        REG_IMAGE_HEIGHT: height_nxt = cfg_wdata;
        default:          width_nxt  = width_r;
      endcase
      // new image: restart at the origin
      tile_x_nxt = '0;
      tile_y_nxt = '0;
      sub_nxt    = '0;
    end else if (accept) begin
      if (sub_r == 2'd3) begin
        sub_nxt = '0;
        if (tile_x_step >= w_eff) begin
          tile_x_nxt = '0;
          tile_y_nxt = (tile_y_step >= h_eff) ? '0 : tile_y_step;
        end else begin
          tile_x_nxt = tile_x_step;
        end
      end else begin
        sub_nxt = sub_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
      tile_x_r <= '0;
      tile_y_r <= '0;
      sub_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      tile_x_r <= tile_x_nxt;
      tile_y_r <= tile_y_nxt;
      sub_r    <= sub_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode: palette, index unpack, in-image mask
  // ---------------------------------------------------------------------------
  logic [PW-1:0]              sx, sy;
  logic [TEXELS-1:0]          mask_new;
  logic [TEXELS-1:0][1:0]     idx_new;
  rgba_t [3:0]                pal_new;
  logic                       four_color;
  logic [7:0]                 r0, g0, b0, r1, g1, b1;

  assign sx = tile_x_r + PW'({sub_r[0], 2'b00});
  assign sy = tile_y_r + PW'({sub_r[1], 2'b00});

  always_comb begin
    for (int k = 0; k < TEXELS; k++) begin
      mask_new[k] = ((sx + PW'(k & 3)) < w_eff) && ((sy + PW'(k >> 2)) < h_eff);
      idx_new[k]  = in_item.index_rows[31 - 2 * k -: 2];
    end
  end

  assign r0 = expand5(in_item.endpoint_first[15:11]);
  assign g0 = expand6(in_item.endpoint_first[10:5]);
  assign b0 = expand5(in_item.endpoint_first[4:0]);
  assign r1 = expand5(in_item.endpoint_second[15:11]);
  assign g1 = expand6(in_item.endpoint_second[10:5]);
  assign b1 = expand5(in_item.endpoint_second[4:0]);

  assign four_color = in_item.endpoint_first > in_item.endpoint_second;

  always_comb begin
    pal_new[0] = '{red: r0, green: g0, blue: b0, alpha: ALPHA_OPAQUE};
    pal_new[1] = '{red: r1, green: g1, blue: b1, alpha: ALPHA_OPAQUE};
    if (four_color) begin
      pal_new[2] = '{red: blend58(r0, r1), green: blend58(g0, g1),
                     blue: blend58(b0, b1), alpha: ALPHA_OPAQUE};
      pal_new[3] = '{red: blend58(r1, r0), green: blend58(g1, g0),
                     blue: blend58(b1, b0), alpha: ALPHA_OPAQUE};
    end else begin
      pal_new[2] = '{red: half(r0, r1), green: half(g0, g1),
                     blue: half(b0, b1), alpha: ALPHA_OPAQUE};
      pal_new[3] = '{red: half(r0, r1), green: half(g0, g1),
                     blue: half(b0, b1), alpha: ALPHA_CLEAR};
    end
  end

  // ---------------------------------------------------------------------------
  // Decoded sub-block register and texel walk
  // ---------------------------------------------------------------------------
  logic                   dec_valid_r, dec_valid_nxt;
  logic [TEXELS-1:0]      dec_mask_r, dec_mask_nxt;
  logic [TEXELS-1:0][1:0] dec_idx_r, dec_idx_nxt;
  rgba_t [3:0]            dec_pal_r, dec_pal_nxt;
  logic [PW-1:0]          dec_sx_r, dec_sx_nxt;
  logic [PW-1:0]          dec_sy_r, dec_sy_nxt;

  logic [3:0]        sel;
  logic [TEXELS-1:0] rest;
  logic              emit;
  logic              last;

  // lowest pending texel, row-major
  always_comb begin
    sel = '0;
    for (int k = TEXELS - 1; k >= 0; k--) begin
      if (dec_mask_r[k]) sel = 4'(k);
    end
  end

  assign rest     = dec_mask_r & ~(TEXELS'(1) << sel);
  assign last     = (rest == '0);
  assign emit     = dec_valid_r && (!out_valid || out_ready);
  assign in_ready = !dec_valid_r || (emit && last);

  always_comb begin
    dec_valid_nxt = dec_valid_r;
    dec_mask_nxt  = dec_mask_r;
    dec_idx_nxt   = dec_idx_r;
    dec_pal_nxt   = dec_pal_r;
    dec_sx_nxt    = dec_sx_r;
    dec_sy_nxt    = dec_sy_r;
    if (accept) begin
      // a sub-block wholly outside the image emits nothing
      dec_valid_nxt = |mask_new;
      dec_mask_nxt  = mask_new;
      dec_idx_nxt   = idx_new;
      dec_pal_nxt   = pal_new;
      dec_sx_nxt    = sx;
      dec_sy_nxt    = sy;
    end else if (emit) begin
      dec_mask_nxt  = rest;
      dec_valid_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_valid_r <= 1'b0;
    end else begin
      dec_valid_r <= dec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dec_mask_r <= dec_mask_nxt;
    dec_idx_r  <= dec_idx_nxt;
    dec_pal_r  <= dec_pal_nxt;
    dec_sx_r   <= dec_sx_nxt;
    dec_sy_r   <= dec_sy_nxt;
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  rgba_t     texel_color;
  logic [PW-1:0] px, py;

  assign texel_color = dec_pal_r[dec_idx_r[sel]];
  assign px = dec_sx_r + PW'(sel[1:0]);
  assign py = dec_sy_r + PW'(sel[3:2]);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.pixel_x    = 10'(px);
      out_item_nxt.pixel_y    = 10'(py);
      out_item_nxt.red        = texel_color.red;
      out_item_nxt.green      = texel_color.green;
      out_item_nxt.blue       = texel_color.blue;
      out_item_nxt.alpha      = texel_color.alpha;
      out_item_nxt.last_texel = last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

[rtl/ctd_checker.sv]
`default_nettype none

module ctd_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input ctd_pkg::out_item_t  out_item
);

  import ctd_pkg::*;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled texel holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled texel changed");

  // Alpha is only ever opaque or fully clear
  a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.alpha == ALPHA_OPAQUE || out_item.alpha == ALPHA_CLEAR))
    else $error("bad alpha code");

  // Input is held off only while texels are still being delivered
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> out_valid)
    else $error("input stalled with no texel pending");

endmodule

bind cmpr_block_texel_decoder ctd_checker u_ctd_checker (.*);

`default_nettype wire

[tb/sv/tb_cmpr_block_texel_decoder.sv]
`default_nettype none

module tb_cmpr_block_texel_decoder;
  import ctd_pkg::*;

  localparam int MAX_DIM       = 1024;
  localparam int SETTLE_CYCLES = 4;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int OUT_HOLD      = 400;
  localparam int MAX_PRINTS    = 30;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // sub-blocks waiting to be sent, texels waiting to come back
  in_item_t  sub_block_q [$];
  out_item_t texel_q [$];

  // decoder state as the testbench sees it
  logic [CFG_DATA_W-1:0] img_w = DIM_RESET;
  logic [CFG_DATA_W-1:0] img_h = DIM_RESET;
  int tile_x = 0;
  int tile_y = 0;
  int quad   = 0;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        in_took = 1'b0;
  int          in_count = 0;
  int          texel_count = 0;
  int          mismatch_count = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned cycle_count = 0;
  out_item_t   want_texel;

  cmpr_block_texel_decoder #(
    .MAX_DIM(MAX_DIM)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("texel %0d: %s got %0d, wanted %0d", texel_count, what, got, want);
    end
    mismatch_count++;
  endtask

  // Expand endpoints, build the palette, emit in-image texels, step the tile walk
  task automatic decode_sub_block(input in_item_t blk);
    logic [7:0] c0 [3];
    logic [7:0] c1 [3];
    logic [7:0] mix2 [3];
    logic [7:0] mix3 [3];
    rgba_t      pal [4];
    out_item_t  burst [16];
    logic       four_color;
    logic [1:0] sel;
    int         w, h, sx, sy, px, py, n, ch, tx, ty, tmp;
    c0[0] = {blk.endpoint_first[15:11], blk.endpoint_first[15:13]};
    c0[1] = {blk.endpoint_first[10:5], blk.endpoint_first[10:9]};
    c0[2] = {blk.endpoint_first[4:0], blk.endpoint_first[4:2]};
    c1[0] = {blk.endpoint_second[15:11], blk.endpoint_second[15:13]};
    c1[1] = {blk.endpoint_second[10:5], blk.endpoint_second[10:9]};
    c1[2] = {blk.endpoint_second[4:0], blk.endpoint_second[4:2]};
    four_color = blk.endpoint_first > blk.endpoint_second;
    for (ch = 0; ch < 3; ch++) begin
      if (four_color) begin
        tmp = (5 * c0[ch] + 3 * c1[ch]) >> 3;
        mix2[ch] = tmp[7:0];
        tmp = (5 * c1[ch] + 3 * c0[ch]) >> 3;
        mix3[ch] = tmp[7:0];
      end else begin
        tmp = (c0[ch] + c1[ch]) >> 1;
        mix2[ch] = tmp[7:0];
        mix3[ch] = tmp[7:0];
      end
    end
    pal[0] = {c0[0], c0[1], c0[2], ALPHA_OPAQUE};
    pal[1] = {c1[0], c1[1], c1[2], ALPHA_OPAQUE};
    pal[2] = {mix2[0], mix2[1], mix2[2], ALPHA_OPAQUE};
    pal[3] = {mix3[0], mix3[1], mix3[2], four_color ? ALPHA_OPAQUE : ALPHA_CLEAR};

    // oversized registers act as MAX_DIM
    w = img_w;
    h = img_h;
    if (w > MAX_DIM) w = MAX_DIM;
    if (h > MAX_DIM) h = MAX_DIM;
    sx = tile_x + (quad % 2) * 4;
    sy = tile_y + (quad / 2) * 4;
    n = 0;
    for (ty = 0; ty < 4; ty++) begin
      for (tx = 0; tx < 4; tx++) begin
        px = sx + tx;
        py = sy + ty;
        sel = blk.index_rows[31 - 8 * ty - 2 * tx -: 2];
        if (px < w && py < h) begin
          burst[n] = {px[9:0], py[9:0], pal[sel].red, pal[sel].green, pal[sel].blue,
                      pal[sel].alpha, 1'b0};
          n++;
        end
      end
    end
    if (n > 0) burst[n - 1].last_texel = 1'b1;
    for (tx = 0; tx < n; tx++) texel_q.push_back(burst[tx]);

    // tile walk: four quads, tiles left to right, then down, wrap at the end
    if (quad == 3) begin
      quad = 0;
      tile_x += 8;
      if (tile_x >= w) begin
        tile_x = 0;
        tile_y += 8;
        if (tile_y >= h) tile_y = 0;
      end
    end else begin
      quad++;
    end
  endtask

  function automatic in_item_t make_sub_block(input logic [15:0] e0, input logic [15:0] e1,
                                              input logic [31:0] rows);
    in_item_t blk;
    blk.endpoint_first  = e0;
    blk.endpoint_second = e1;
    blk.index_rows      = rows;
    return blk;
  endfunction

  // Random sub-block, biased toward equal and extreme endpoints and repeated index rows
  function automatic in_item_t random_sub_block();
    logic [31:0] r;
    logic [31:0] rows;
    r    = $urandom;
    rows = $urandom;
    case ($urandom_range(7))
      0: r[31:16] = r[15:0];
      1: r = {$urandom_range(1) ? 16'hFFFF : 16'h0000, $urandom_range(1) ? 16'hFFFF : 16'h0000};
      2: rows = {4{rows[7:0]}};
      default: ;
    endcase
    return make_sub_block(r[15:0], r[31:16], rows);
  endfunction

  // Wait until nothing is queued, in flight or expected, then let the pipe settle;
  // sampled at the rising edge, where the driver's queue and valid are stable
  task automatic wait_idle();
    while (sub_block_q.size() != 0 || in_valid || texel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Size write; also restarts the tile walk at the origin
  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) img_w = value[CFG_DATA_W-1:0];
    else img_h = value[CFG_DATA_W-1:0];
    tile_x = 0;
    tile_y = 0;
    quad   = 0;
  endtask

  task automatic run_image(input int w, input int h, input int count);
    wait_idle();
    write_size(REG_IMAGE_WIDTH, w);
    write_size(REG_IMAGE_HEIGHT, h);
    repeat (count) sub_block_q.push_back(random_sub_block());
  endtask

  // Driver: hold the item until taken, then maybe idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (sub_block_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= sub_block_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off while the sender keeps pushing
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_count >= 100 && sub_block_q.size() >= 20) begin
      out_ready <= 1'b0;
      hold_left <= OUT_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        decode_sub_block(in_item);
        in_count++;
      end
      if (out_valid && out_ready) begin
        if (texel_q.size() == 0) begin
          report_mismatch("texel with none pending, pixel_x", out_item.pixel_x, 0);
        end else begin
          want_texel = texel_q.pop_front();
          if (out_item.pixel_x !== want_texel.pixel_x)
            report_mismatch("pixel_x", out_item.pixel_x, want_texel.pixel_x);
          if (out_item.pixel_y !== want_texel.pixel_y)
            report_mismatch("pixel_y", out_item.pixel_y, want_texel.pixel_y);
          if (out_item.red !== want_texel.red)
            report_mismatch("red", out_item.red, want_texel.red);
          if (out_item.green !== want_texel.green)
            report_mismatch("green", out_item.green, want_texel.green);
          if (out_item.blue !== want_texel.blue)
            report_mismatch("blue", out_item.blue, want_texel.blue);
          if (out_item.alpha !== want_texel.alpha)
            report_mismatch("alpha", out_item.alpha, want_texel.alpha);
          if (out_item.last_texel !== want_texel.last_texel)
            report_mismatch("last_texel", out_item.last_texel, want_texel.last_texel);
        end
        texel_count++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset size 8x8: both palette modes, equal endpoints, extremes
    send_idle_pct = 32;
    recv_idle_pct = 84;
    sub_block_q.push_back(make_sub_block(16'hFFFF, 16'h0000, 32'h1B1B1B1B));
    sub_block_q.push_back(make_sub_block(16'h0000, 16'hFFFF, 32'h1B1B1B1B));
    sub_block_q.push_back(make_sub_block(16'h8410, 16'h8410, 32'hFFFFFFFF));
    sub_block_q.push_back(make_sub_block(16'hF800, 16'h07E0, 32'hE4E4E4E4));
    sub_block_q.push_back(make_sub_block(16'h001F, 16'hF81F, 32'h00000000));
    sub_block_q.push_back(make_sub_block(16'hFFFF, 16'hFFFE, 32'hAAAAAAAA));
    sub_block_q.push_back(make_sub_block(16'h0001, 16'h0000, 32'h55555555));
    sub_block_q.push_back(make_sub_block(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF));

    // Narrow image: right quads fall fully outside, walk wraps
    run_image(3, 12, 6);
    // Rewrite mid-tile restarts the walk
    wait_idle();
    write_size(REG_IMAGE_HEIGHT, 12);
    repeat (2) sub_block_q.push_back(random_sub_block());
    // Zero width: nothing comes out
    run_image(0, 12, 2);
    // Oversized width, single row
    run_image(2047, 1, 2);

    // Random images
    run_image(13, 11, 60);
    run_image(1, 1, 30);
    run_image(1024, 1024, 70);
    wait_idle();
    send_idle_pct = 84;
    recv_idle_pct = 32;
    run_image(2047, 5, 50);
    run_image(0, 9, 10);
    run_image(37, 2, 50);
    run_image(20, 0, 10);
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_image(1, 1024, 50);
    run_image(16, 16, 60);
    run_image(9, 1030, 50);
    run_image(8, 8, 40);

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
